### design/cod_pkg.sv
// ----------------------------------------------------------------------------
// cod_pkg: shared types and constants
// Table geometry, register map, event codes and the table entry layout for
// the call overlap event detector.
// ----------------------------------------------------------------------------
`default_nettype none

package cod_pkg;

    // client table geometry
    localparam int CLIENT_ENTRIES = 1024;
    localparam int IDX_W          = $clog2(CLIENT_ENTRIES);
    localparam int ADDR_W         = 32;
    localparam int TAG_W          = ADDR_W - IDX_W;

    // field widths
    localparam int TS_W    = 48;
    localparam int GAP_W   = 32;
    localparam int PROTO_W = 16;

    // configuration port
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    typedef enum logic [2:0] {
        REG_VOICE_PROTO = 3'd0,
        REG_WATCHED_A   = 3'd1,
        REG_WATCHED_B   = 3'd2,
        REG_OPEN_GAP    = 3'd3,
        REG_CALL_GAP    = 3'd4
    } reg_idx_t;

    localparam logic [PROTO_W-1:0] VOICE_PROTO_RST = '0;
    localparam logic [ADDR_W-1:0]  WATCHED_A_RST   = 32'h830E_36C2;
    localparam logic [ADDR_W-1:0]  WATCHED_B_RST   = 32'hF1B5_B55F;
    localparam logic [GAP_W-1:0]   OPEN_GAP_RST    = 32'd30000000;
    localparam logic [GAP_W-1:0]   CALL_GAP_RST    = 32'd30000000;

    typedef enum logic [1:0] {
        EV_CALL_START = 2'd0,
        EV_OPEN       = 2'd1,
        EV_OVERLAP    = 2'd2
    } ev_kind_t;

    typedef struct packed {
        logic [PROTO_W-1:0] voice_proto;
        logic [ADDR_W-1:0]  watched_a;
        logic [ADDR_W-1:0]  watched_b;
        logic [GAP_W-1:0]   open_gap;
        logic [GAP_W-1:0]   call_gap;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        logic [TS_W-1:0]  watched_last;
        logic [TS_W-1:0]  call_last;
        logic [TS_W-1:0]  call_start;
        logic [TS_W-1:0]  reported_start;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // events produced by one packet, in delivery order
    typedef struct packed {
        logic [1:0] count;
        ev_kind_t   kind0;
        ev_kind_t   kind1;
    } evset_t;

endpackage

`default_nettype wire

### design/cod_ram.sv
// ----------------------------------------------------------------------------
// cod_ram: simple dual-port synchronous memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cod_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/cod_cfg.sv
// ----------------------------------------------------------------------------
// cod_cfg: configuration registers
// APB-style register file holding the voice protocol, watched addresses and
// the two idle gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module cod_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cod_pkg::CFG_AW-1:0] paddr,
    input  logic [cod_pkg::CFG_DW-1:0] pwdata,
    output logic [cod_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    output cod_pkg::cfg_t              cfg
);
    import cod_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t sel;
    logic     wr_en;

    // word address, byte offset ignored
    assign sel   = reg_idx_t'(paddr[CFG_AW-1:2]);
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.voice_proto <= VOICE_PROTO_RST;
            cfg_reg.watched_a   <= WATCHED_A_RST;
            cfg_reg.watched_b   <= WATCHED_B_RST;
            cfg_reg.open_gap    <= OPEN_GAP_RST;
            cfg_reg.call_gap    <= CALL_GAP_RST;
        end
        else if (wr_en)
        begin
            unique case (sel)
                REG_VOICE_PROTO: cfg_reg.voice_proto <= pwdata[PROTO_W-1:0];
                REG_WATCHED_A:   cfg_reg.watched_a   <= pwdata;
                REG_WATCHED_B:   cfg_reg.watched_b   <= pwdata;
                REG_OPEN_GAP:    cfg_reg.open_gap    <= pwdata;
                REG_CALL_GAP:    cfg_reg.call_gap    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_VOICE_PROTO: prdata = {{(CFG_DW-PROTO_W){1'b0}}, cfg_reg.voice_proto};
            REG_WATCHED_A:   prdata = cfg_reg.watched_a;
            REG_WATCHED_B:   prdata = cfg_reg.watched_b;
            REG_OPEN_GAP:    prdata = cfg_reg.open_gap;
            REG_CALL_GAP:    prdata = cfg_reg.call_gap;
            default:         prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

endmodule

`default_nettype wire

### design/cod_rule.sv
// ----------------------------------------------------------------------------
// cod_rule: per-packet session update
// Takes the table entry read for one packet, applies the call and watched
// rules, and returns the entry to write back and the events to deliver.
// ----------------------------------------------------------------------------
`default_nettype none

module cod_rule (
    input  cod_pkg::entry_t                 entry,
    input  logic [cod_pkg::ADDR_W-1:0]      item_src,
    input  logic [cod_pkg::TS_W-1:0]        item_now,
    input  logic                            item_voice,
    input  cod_pkg::cfg_t                   cfg,
    output cod_pkg::entry_t                 entry_new,
    output cod_pkg::evset_t                 evs
);
    import cod_pkg::*;

    logic [TAG_W-1:0] tag;
    logic             hit;
    entry_t           base;
    logic [TS_W:0]    call_end;
    logic [TS_W:0]    open_end;
    logic             call_over;
    logic             open_fire;
    logic [TS_W-1:0]  call_kept;
    logic             ovl_fire;

    assign tag = item_src[ADDR_W-1:IDX_W];
    assign hit = entry.valid && (entry.tag == tag);

    // miss or tag conflict: start from a fresh entry with zero timestamps
    always_comb
    begin
        if (hit)
        begin
            base = entry;
        end
        else
        begin
            base       = '0;
            base.valid = 1'b1;
            base.tag   = tag;
        end
    end

    assign call_end  = {1'b0, base.call_last} + {{(TS_W+1-GAP_W){1'b0}}, cfg.call_gap};
    assign open_end  = {1'b0, base.watched_last} + {{(TS_W+1-GAP_W){1'b0}}, cfg.open_gap};
    assign call_over = call_end < {1'b0, item_now};
    assign open_fire = open_end < {1'b0, item_now};
    assign call_kept = call_over ? '0 : base.call_last;
    assign ovl_fire  = (call_kept != '0) && (base.call_start != base.reported_start);

    always_comb
    begin
        entry_new = base;
        evs.count = 2'd0;
        evs.kind0 = EV_CALL_START;
        evs.kind1 = EV_CALL_START;
        if (item_voice)
        begin
            entry_new.call_last = item_now;
            if (call_over)
            begin
                entry_new.call_start = item_now;
                evs.count            = 2'd1;
            end
        end
        else
        begin
            entry_new.watched_last = item_now;
            entry_new.call_last    = call_kept;
            if (ovl_fire)
            begin
                entry_new.reported_start = base.call_start;
            end
            // watched open goes first, overlap second
            if (open_fire && ovl_fire)
            begin
                evs.count = 2'd2;
                evs.kind0 = EV_OPEN;
                evs.kind1 = EV_OVERLAP;
            end
            else if (open_fire)
            begin
                evs.count = 2'd1;
                evs.kind0 = EV_OPEN;
            end
            else if (ovl_fire)
            begin
                evs.count = 2'd1;
                evs.kind0 = EV_OVERLAP;
            end
        end
    end

endmodule

`default_nettype wire

### design/call_overlap_event_detector.sv
// ----------------------------------------------------------------------------
// call_overlap_event_detector: voice call / watched traffic event detector
// Tracks per-source session timestamps in a direct-mapped client table and
// reports call starts, watched openings and watched traffic during a call.
// ----------------------------------------------------------------------------
// usage
//   input channel: one packet per transfer (in_valid / in_stall), fields
//     flow_valid, app_proto, master_proto, src_addr, dst_addr, now_us
//   output channel: one event per transfer (out_valid / out_stall), fields
//     event_kind, event_src, event_dst, last_event (set on a packet's final event)
//   a packet yields zero, one or two events
// timing
//   a packet that touches the table has a table read step, then an update
//     and write back step; its first event shows the cycle after the write back
//   a packet that is dropped (flow_valid low, or neither voice nor watched)
//     touches nothing
//   the single table memory port pair sets this: a new packet is taken only
//     after the previous write back, so no two accesses to one entry overlap
// stalls
//   events sit in a two-slot output queue; the next packet is taken while
//     events wait, but its update holds until the queue has drained
// reset
//   after rst_n the table is cleared one entry per cycle, all CLIENT_ENTRIES
//   entries (1024), with in_stall high; configuration writes work throughout
// ----------------------------------------------------------------------------
`default_nettype none

module call_overlap_event_detector (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cod_pkg::CFG_AW-1:0]   paddr,
    input  logic [cod_pkg::CFG_DW-1:0]   pwdata,
    output logic [cod_pkg::CFG_DW-1:0]   prdata,
    output logic                         pready,
    // packet input
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         flow_valid,
    input  logic [cod_pkg::PROTO_W-1:0]  app_proto,
    input  logic [cod_pkg::PROTO_W-1:0]  master_proto,
    input  logic [cod_pkg::ADDR_W-1:0]   src_addr,
    input  logic [cod_pkg::ADDR_W-1:0]   dst_addr,
    input  logic [cod_pkg::TS_W-1:0]     now_us,
    // event output
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   event_kind,
    output logic [cod_pkg::ADDR_W-1:0]   event_src,
    output logic [cod_pkg::ADDR_W-1:0]   event_dst,
    output logic                         last_event
);
    import cod_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } state_t;

    state_t            state_reg;
    logic [IDX_W-1:0]  clr_idx_reg;

    // packet held during the table access
    logic [ADDR_W-1:0] pkt_src_reg;
    logic [ADDR_W-1:0] pkt_dst_reg;
    logic [TS_W-1:0]   pkt_now_reg;
    logic              pkt_voice_reg;

    // output queue: two slots, both events of one packet share addresses
    logic [1:0]        q_cnt_reg;
    ev_kind_t          q_kind0_reg;
    ev_kind_t          q_kind1_reg;
    logic [ADDR_W-1:0] q_src_reg;
    logic [ADDR_W-1:0] q_dst_reg;

    cfg_t              cfg;
    entry_t            rd_entry;
    entry_t            entry_new;
    evset_t            evs;
    logic [ENTRY_W-1:0] rd_data;
    logic [ENTRY_W-1:0] wr_data;
    logic [IDX_W-1:0]  wr_addr;
    logic              wr_en;

    logic [PROTO_W-1:0] proto;
    logic              is_voice;
    logic              is_watched;
    logic              in_xfer;
    logic              in_work;
    logic              out_xfer;
    logic              push;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    cod_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------------
    // packet classification at the input transfer
    // ------------------------------------------------------------------------
    assign proto      = (app_proto != '0) ? app_proto : master_proto;
    assign is_voice   = (proto == cfg.voice_proto);
    assign is_watched = (dst_addr == cfg.watched_a) || (dst_addr == cfg.watched_b) ||
                        (src_addr == cfg.watched_a) || (src_addr == cfg.watched_b);

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    // voice wins over watched; anything else is dropped without a table access
    assign in_work  = in_xfer && flow_valid && (is_voice || is_watched);

    // ------------------------------------------------------------------------
    // client table: read on transfer, write back after the update
    // ------------------------------------------------------------------------
    cod_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CLIENT_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (in_work),
        .raddr (src_addr[IDX_W-1:0]),
        .rdata (rd_data)
    );

    assign rd_entry = entry_t'(rd_data);

    cod_rule u_rule (
        .entry      (rd_entry),
        .item_src   (pkt_src_reg),
        .item_now   (pkt_now_reg),
        .item_voice (pkt_voice_reg),
        .cfg        (cfg),
        .entry_new  (entry_new),
        .evs        (evs)
    );

    // update only once the queue is empty, so both events always fit
    assign push = (state_reg == S_LOOK) && (q_cnt_reg == 2'd0);

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = push;
            wr_addr = pkt_src_reg[IDX_W-1:0];
            wr_data = entry_new;
        end
    end

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + IDX_W'(1);
                    if (clr_idx_reg == IDX_W'(CLIENT_ENTRIES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_work)
                    begin
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    if (push)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_work)
        begin
            pkt_src_reg   <= src_addr;
            pkt_dst_reg   <= dst_addr;
            pkt_now_reg   <= now_us;
            pkt_voice_reg <= is_voice;
        end
    end

    // ------------------------------------------------------------------------
    // output queue
    // ------------------------------------------------------------------------
    assign out_xfer = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_cnt_reg <= 2'd0;
        end
        else if (push)
        begin
            q_cnt_reg <= evs.count;
        end
        else if (out_xfer)
        begin
            q_cnt_reg <= q_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_kind0_reg <= evs.kind0;
            q_kind1_reg <= evs.kind1;
            q_src_reg   <= pkt_src_reg;
            q_dst_reg   <= pkt_dst_reg;
        end
        else if (out_xfer)
        begin
            q_kind0_reg <= q_kind1_reg;
        end
    end

    assign out_valid  = (q_cnt_reg != 2'd0);
    assign event_kind = q_kind0_reg;
    assign event_src  = q_src_reg;
    assign event_dst  = q_dst_reg;
    assign last_event = (q_cnt_reg == 2'd1);

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_push_empty: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (q_cnt_reg == 2'd0))
        else $error("events loaded into a non-empty queue");

    a_work_look: assert property (@(posedge clk) disable iff (!rst_n)
        in_work |=> (state_reg == S_LOOK))
        else $error("table packet did not reach the update step");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && (evs.count != 2'd0)) |=> out_valid)
        else $error("produced event not presented");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !wr_en)
        else $error("table written while idle");

endmodule

`default_nettype wire
